@@ rtl/gblur_pkg.sv @@
// Shared constants, types and the constant-divisor helper of the 3x3 blur.
package gblur_pkg;

    localparam int GB_MAX_WIDTH   = 2048;
    localparam int CHAN_W         = 8;
    localparam int PIX_W          = 3 * CHAN_W;
    localparam int WIDTH_REG_W    = 12;
    localparam int HEIGHT_REG_W   = 16;
    localparam int CFG_DATA_W     = 16;
    localparam int CFG_IDX_W      = 1;
    localparam int IMG_WIDTH_RST  = 640;
    localparam int IMG_HEIGHT_RST = 480;
    localparam int SUM_W          = 12;
    localparam int WSUM_W         = 5;
    localparam int MULT_W         = 16;
    localparam int SHIFT_W        = 5;
    localparam int PROD_W         = SUM_W + MULT_W;

    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH  = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_HEIGHT = 1'd1;

    typedef struct packed {
        logic [MULT_W-1:0]  mult;
        logic [SHIFT_W-1:0] shift;
    } t_div_magic;

    // Multiply-and-shift pair that gives floor(x / wsum) exactly for any sum
    // the window can produce (below 4096).
    function automatic t_div_magic div_magic(input logic [WSUM_W-1:0] wsum);
        t_div_magic m;
        unique case (wsum)
            5'd4:    m = '{mult: 16'd1,     shift: 5'd2};
            5'd6:    m = '{mult: 16'd43691, shift: 5'd18};
            5'd8:    m = '{mult: 16'd1,     shift: 5'd3};
            5'd9:    m = '{mult: 16'd58255, shift: 5'd19};
            5'd12:   m = '{mult: 16'd43691, shift: 5'd19};
            default: m = '{mult: 16'd1,     shift: 5'd4};
        endcase
        return m;
    endfunction

endpackage

@@ rtl/gblur_in_if.sv @@
// Input channel of the blur: pixel or flush item with valid/ready.
interface gblur_in_if;
    import gblur_pkg::*;

    logic              valid;
    logic              ready;
    logic              func;
    logic [CHAN_W-1:0] in_blue;
    logic [CHAN_W-1:0] in_green;
    logic [CHAN_W-1:0] in_red;

    modport source (output valid, func, in_blue, in_green, in_red, input ready);
    modport sink   (input valid, func, in_blue, in_green, in_red, output ready);
endinterface

@@ rtl/gblur_out_if.sv @@
// Output channel of the blur: blurred pixel with end-of-image flag.
interface gblur_out_if;
    import gblur_pkg::*;

    logic              valid;
    logic              ready;
    logic [CHAN_W-1:0] out_blue;
    logic [CHAN_W-1:0] out_green;
    logic [CHAN_W-1:0] out_red;
    logic              end_of_image;

    modport source (output valid, out_blue, out_green, out_red, end_of_image, input ready);
    modport sink   (input valid, out_blue, out_green, out_red, end_of_image, output ready);
endinterface

@@ rtl/gblur_ram.sv @@
// Generic single-clock RAM with one write port and one registered read port.
module gblur_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

@@ rtl/gaussian_blur_3x3_rgb.sv @@
// Streaming 3x3 binomial blur of RGB pixels with border-normalized weights.
//
//   channel   | dir | handshake          | carries
//   ----------+-----+--------------------+------------------------------------
//   i_in      | in  | valid/ready        | func, in_blue, in_green, in_red
//   o_out     | out | valid/ready        | out_blue, out_green, out_red, end_of_image
//   i_cfg_*   | in  | write enable only  | register index, data (width, height)
//
// One item at a time: a flush during fill is dropped in S_IDLE, a pixel without a
// result passes S_PUSH, an item with a result S_PUSH, S_SUM and S_OUT, and the
// first drain tick of a one-row image S_PUSH, S_READ2, S_PUSH, S_SUM and S_OUT.
// The read-modify-write of the line-store memory (registered read, then write
// back in S_PUSH) sets these steps. An item is taken while the previous result
// still sits in the output register; S_OUT waits for that register to free up.
// Reset needs no clearing pass: line-store entries are undefined until written.
module gaussian_blur_3x3_rgb #(
    parameter int MAX_WIDTH = gblur_pkg::GB_MAX_WIDTH
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    gblur_in_if.sink                          i_in,
    gblur_out_if.source                       o_out,
    input  logic                              i_cfg_we,
    input  logic [gblur_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [gblur_pkg::CFG_DATA_W-1:0]  i_cfg_data
);
    import gblur_pkg::*;

    localparam int CW    = $clog2(MAX_WIDTH);
    localparam int WW    = $clog2(MAX_WIDTH + 1);
    localparam int RST_W = (IMG_WIDTH_RST > MAX_WIDTH) ? MAX_WIDTH : IMG_WIDTH_RST;

    typedef enum logic [2:0] {
        S_IDLE,
        S_PUSH,
        S_READ2,
        S_SUM,
        S_OUT
    } t_state;

    t_state                  r_state;
    logic [WW-1:0]           r_w;
    logic [HEIGHT_REG_W-1:0] r_h;
    logic [CW-1:0]           r_col;
    logic [HEIGHT_REG_W-1:0] r_row;
    logic [CW-1:0]           r_ocol;
    logic [HEIGHT_REG_W-1:0] r_orow;
    logic                    r_emit;
    logic                    r_dbl;
    logic [PIX_W-1:0]        r_pix;
    logic [PIX_W-1:0]        r_win [9];
    logic [SUM_W-1:0]        r_sum [3];
    logic [MULT_W-1:0]       r_mult;
    logic [SHIFT_W-1:0]      r_shift;
    logic                    r_eoi;
    logic                    r_out_valid;
    logic [CHAN_W-1:0]       r_out_ch [3];
    logic                    r_out_eoi;

    logic [2*PIX_W-1:0]      ram_rdata;
    logic [PIX_W-1:0]        up_pix;
    logic [PIX_W-1:0]        mid_pix;

    logic                    in_fire;
    logic                    filling;
    logic [WW-1:0]           col_inc;
    logic [WW-1:0]           ocol_inc;
    logic [2:0]              row_use;
    logic [2:0]              col_use;
    logic [2:0]              row_wt;
    logic [2:0]              col_wt;
    logic [WSUM_W-1:0]       wsum;
    t_div_magic              magic;
    logic                    last;
    logic [SUM_W-1:0]        n_sum [3];
    logic [CHAN_W-1:0]       n_out_ch [3];
    logic                    out_free;
    logic [WIDTH_REG_W-1:0]  cfg_w;

    // Each entry holds {upper row pixel, middle row pixel} of one column.
    gblur_ram #(
        .WIDTH (2 * PIX_W),
        .DEPTH (MAX_WIDTH)
    ) u_line_ram (
        .i_clk   (i_clk),
        .i_we    (r_state == S_PUSH),
        .i_waddr (r_col),
        .i_wdata ({mid_pix, r_pix}),
        .i_raddr (r_col),
        .o_rdata (ram_rdata)
    );

    assign up_pix  = ram_rdata[2*PIX_W-1:PIX_W];
    assign mid_pix = ram_rdata[PIX_W-1:0];

    assign i_in.ready = (r_state == S_IDLE);
    assign in_fire    = i_in.valid && i_in.ready;
    assign filling    = (r_row < r_h);
    assign col_inc    = WW'(r_col) + WW'(1);
    assign ocol_inc   = WW'(r_ocol) + WW'(1);
    assign out_free   = !r_out_valid || o_out.ready;
    assign cfg_w      = i_cfg_data[WIDTH_REG_W-1:0];

    // Taps outside the image are left out of both the sum and the weight.
    assign row_use[0] = (r_orow != '0);
    assign row_use[1] = 1'b1;
    assign row_use[2] = ((17'(r_orow) + 17'd1) < 17'(r_h));
    assign col_use[0] = (r_ocol != '0);
    assign col_use[1] = 1'b1;
    assign col_use[2] = (ocol_inc < r_w);
    assign row_wt     = 3'd2 + 3'(row_use[0]) + 3'(row_use[2]);
    assign col_wt     = 3'd2 + 3'(col_use[0]) + 3'(col_use[2]);
    assign wsum       = WSUM_W'(row_wt) * WSUM_W'(col_wt);
    assign magic      = div_magic(wsum);
    assign last       = (r_orow == (r_h - 16'd1)) && (ocol_inc == r_w);

    always_comb begin
        for (int ch = 0; ch < 3; ch++) begin
            n_sum[ch] = '0;
            for (int r = 0; r < 3; r++) begin
                for (int c = 0; c < 3; c++) begin
                    if (row_use[r] && col_use[c]) begin
                        n_sum[ch] = n_sum[ch]
                            + (SUM_W'(r_win[r*3+c][ch*CHAN_W +: CHAN_W])
                               << (((r == 1) ? 1 : 0) + ((c == 1) ? 1 : 0)));
                    end
                end
            end
        end
    end

    always_comb begin
        logic [PROD_W-1:0] prod;
        logic [PROD_W-1:0] quot;
        for (int ch = 0; ch < 3; ch++) begin
            prod         = PROD_W'(r_sum[ch]) * PROD_W'(r_mult);
            quot         = prod >> r_shift;
            n_out_ch[ch] = quot[CHAN_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_w         <= WW'(RST_W);
            r_h         <= HEIGHT_REG_W'(IMG_HEIGHT_RST);
            r_col       <= '0;
            r_row       <= '0;
            r_ocol      <= '0;
            r_orow      <= '0;
            r_emit      <= 1'b0;
            r_dbl       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if ((r_state == S_OUT) && out_free) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end

            unique case (r_state)
                S_IDLE: begin
                    if (in_fire) begin
                        if (filling) begin
                            if (!i_in.func) begin
                                r_pix   <= {i_in.in_red, i_in.in_green, i_in.in_blue};
                                r_emit  <= (r_row >= 16'd2)
                                           || ((r_row == 16'd1) && (r_col != '0));
                                r_dbl   <= 1'b0;
                                r_state <= S_PUSH;
                            end
                        end else begin
                            // Draining: the item pushes a blank pixel (twice on the first tick of a one-row image).
                            r_pix   <= '0;
                            r_emit  <= 1'b1;
                            r_dbl   <= (r_h == 16'd1) && (r_orow == '0) && (r_ocol == '0);
                            r_state <= S_PUSH;
                        end
                    end
                end
                S_PUSH: begin
                    for (int r = 0; r < 3; r++) begin
                        r_win[r*3]   <= r_win[r*3+1];
                        r_win[r*3+1] <= r_win[r*3+2];
                    end
                    r_win[2] <= up_pix;
                    r_win[5] <= mid_pix;
                    r_win[8] <= r_pix;
                    if (col_inc == r_w) begin
                        r_col <= '0;
                        if (r_row < r_h) begin
                            r_row <= r_row + 16'd1;
                        end
                    end else begin
                        r_col <= CW'(col_inc);
                    end
                    r_pix <= '0;
                    // A second push rereads the store only after this write lands.
                    priority if (r_dbl) begin
                        r_dbl   <= 1'b0;
                        r_state <= S_READ2;
                    end else if (r_emit) begin
                        r_state <= S_SUM;
                    end else begin
                        r_state <= S_IDLE;
                    end
                end
                S_READ2: begin
                    r_state <= S_PUSH;
                end
                S_SUM: begin
                    r_sum   <= n_sum;
                    r_mult  <= magic.mult;
                    r_shift <= magic.shift;
                    r_eoi   <= last;
                    if (last) begin
                        r_col  <= '0;
                        r_row  <= '0;
                        r_ocol <= '0;
                        r_orow <= '0;
                    end else if (ocol_inc == r_w) begin
                        r_ocol <= '0;
                        r_orow <= r_orow + 16'd1;
                    end else begin
                        r_ocol <= CW'(ocol_inc);
                    end
                    r_state <= S_OUT;
                end
                S_OUT: begin
                    if (out_free) begin
                        r_out_ch  <= n_out_ch;
                        r_out_eoi <= r_eoi;
                        r_state   <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase

            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    CFG_IMAGE_WIDTH: begin
                        priority if (cfg_w == '0) begin
                            r_w <= WW'(1);
                        end else if (32'(cfg_w) > 32'(MAX_WIDTH)) begin
                            r_w <= WW'(MAX_WIDTH);
                        end else begin
                            r_w <= WW'(cfg_w);
                        end
                    end
                    CFG_IMAGE_HEIGHT: begin
                        r_h <= (i_cfg_data == '0) ? 16'd1 : i_cfg_data;
                    end
                    default: begin
                        r_h <= r_h;
                    end
                endcase
                r_col  <= '0;
                r_row  <= '0;
                r_ocol <= '0;
                r_orow <= '0;
            end
        end
    end

    assign o_out.valid        = r_out_valid;
    assign o_out.out_blue     = r_out_ch[0];
    assign o_out.out_green    = r_out_ch[1];
    assign o_out.out_red      = r_out_ch[2];
    assign o_out.end_of_image = r_out_eoi;
endmodule

@@ dv/gaussian_blur_3x3_rgb_tb.sv @@
// Self-checking testbench of the streaming 3x3 RGB blur with its own pixel predictor.
module gaussian_blur_3x3_rgb_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import gblur_pkg::*;

    localparam bit          FUNC_PIXEL    = 1'b0;
    localparam bit          FUNC_FLUSH    = 1'b1;
    localparam int unsigned ITEM_TARGET   = 850;
    localparam int unsigned CALM_TAIL     = 150;
    localparam int unsigned SETTLE_CYCLES = 10;
    localparam int unsigned DRAIN_CYCLES  = 20;
    localparam int unsigned STALL_LIMIT   = 300;
    localparam int unsigned REPORT_MAX    = 10;

    typedef struct packed {
        logic [CHAN_W-1:0] out_blue;
        logic [CHAN_W-1:0] out_green;
        logic [CHAN_W-1:0] out_red;
        logic              end_of_image;
    } t_blur_pixel;

    class blur_scoreboard;
        logic [WIDTH_REG_W-1:0]  width_reg;
        logic [HEIGHT_REG_W-1:0] height_reg;
        logic [PIX_W-1:0]        row_above [GB_MAX_WIDTH];
        logic [PIX_W-1:0]        row_middle [GB_MAX_WIDTH];
        logic [PIX_W-1:0]        window [9];
        int unsigned             col_in;
        int unsigned             row_in;
        longint unsigned         out_index;
        t_blur_pixel             expected_pixels [$];
        int unsigned             mismatches;
        int unsigned             checked;
        int unsigned             images_done;

        function new();
            width_reg  = WIDTH_REG_W'(IMG_WIDTH_RST);
            height_reg = HEIGHT_REG_W'(IMG_HEIGHT_RST);
            foreach (row_above[i]) begin
                row_above[i]  = '0;
                row_middle[i] = '0;
            end
            foreach (window[i]) window[i] = '0;
            col_in      = 0;
            row_in      = 0;
            out_index   = 0;
            mismatches  = 0;
            checked     = 0;
            images_done = 0;
        endfunction

        function int unsigned frame_width();
            if (width_reg == 0) return 1;
            if (width_reg > GB_MAX_WIDTH) return GB_MAX_WIDTH;
            return 32'(width_reg);
        endfunction

        function int unsigned frame_height();
            return (height_reg == 0) ? 1 : 32'(height_reg);
        endfunction

        // Either register write starts a fresh image.
        function void write_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
            if (idx == CFG_IMAGE_WIDTH) begin
                width_reg = value[WIDTH_REG_W-1:0];
            end else begin
                height_reg = value[HEIGHT_REG_W-1:0];
            end
            col_in    = 0;
            row_in    = 0;
            out_index = 0;
        endfunction

        function void shift_column(logic [PIX_W-1:0] pix, int unsigned w, int unsigned h);
            int unsigned      c;
            logic [PIX_W-1:0] up;
            logic [PIX_W-1:0] mid;
            c = (col_in >= w) ? 0 : col_in;
            up  = row_above[c];
            mid = row_middle[c];
            row_above[c]  = mid;
            row_middle[c] = pix;
            for (int r = 0; r < 3; r++) begin
                window[r*3]   = window[r*3+1];
                window[r*3+1] = window[r*3+2];
            end
            window[2] = up;
            window[5] = mid;
            window[8] = pix;
            c++;
            if (c >= w) begin
                c = 0;
                if (row_in < h) row_in++;
            end
            col_in = c;
        endfunction

        // Weighted sum over the taps inside the image, divided by the weight used.
        function void blur_center(int unsigned w, int unsigned h);
            longint unsigned  total;
            longint unsigned  orow;
            longint unsigned  ocol;
            int unsigned      acc [3];
            int unsigned      wsum;
            int unsigned      wt;
            logic [PIX_W-1:0] p;
            t_blur_pixel      px;
            total = longint'(w) * h;
            orow  = out_index / w;
            ocol  = out_index % w;
            acc   = '{0, 0, 0};
            wsum  = 0;
            for (int r = 0; r < 3; r++) begin
                if (r == 0 && orow == 0) continue;
                if (r == 2 && orow + 1 >= h) continue;
                for (int c = 0; c < 3; c++) begin
                    if (c == 0 && ocol == 0) continue;
                    if (c == 2 && ocol + 1 >= w) continue;
                    wt = ((r == 1) ? 2 : 1) * ((c == 1) ? 2 : 1);
                    p  = window[r*3+c];
                    wsum += wt;
                    for (int ch = 0; ch < 3; ch++) acc[ch] += wt * p[8*ch +: 8];
                end
            end
            px.out_blue     = CHAN_W'(acc[0] / wsum);
            px.out_green    = CHAN_W'(acc[1] / wsum);
            px.out_red      = CHAN_W'(acc[2] / wsum);
            px.end_of_image = (out_index + 1 >= total);
            out_index++;
            if (px.end_of_image) begin
                row_in    = 0;
                col_in    = 0;
                out_index = 0;
            end
            expected_pixels.push_back(px);
        endfunction

        function void note_input(bit flush, logic [PIX_W-1:0] pix);
            int unsigned     w;
            int unsigned     h;
            longint unsigned n;
            w = frame_width();
            h = frame_height();
            if (row_in < h) begin
                // Flush ticks do nothing until the whole image has arrived.
                if (flush) return;
                n = longint'(row_in) * w + col_in;
                shift_column(pix, w, h);
                if (n >= longint'(w) + 1) blur_center(w, h);
            end else begin
                // Draining: pixel items count as flush ticks here.
                shift_column('0, w, h);
                if (h == 1 && out_index == 0) shift_column('0, w, h);
                blur_center(w, h);
            end
        endfunction

        function void check_result(t_blur_pixel got);
            t_blur_pixel want;
            checked++;
            if (expected_pixels.size() == 0) begin
                mismatches++;
                if (mismatches <= REPORT_MAX)
                    $display("result %0d with no pixel pending: b=%h g=%h r=%h eoi=%b",
                             checked, got.out_blue, got.out_green, got.out_red,
                             got.end_of_image);
                return;
            end
            want = expected_pixels.pop_front();
            if (want.end_of_image) images_done++;
            if (got.out_blue !== want.out_blue || got.out_green !== want.out_green ||
                got.out_red !== want.out_red || got.end_of_image !== want.end_of_image) begin
                mismatches++;
                if (mismatches <= REPORT_MAX) begin
                    $display("mismatch at result %0d: expected b=%h g=%h r=%h eoi=%b,",
                             checked, want.out_blue, want.out_green, want.out_red,
                             want.end_of_image);
                    $display("    got b=%h g=%h r=%h eoi=%b",
                             got.out_blue, got.out_green, got.out_red, got.end_of_image);
                end
            end
        endfunction
    endclass

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_idx;
    logic [CFG_DATA_W-1:0] i_cfg_data;

    gblur_in_if  in_ch ();
    gblur_out_if out_ch ();

    blur_scoreboard board;
    bit             idling_on;
    int unsigned    stall_left;
    int unsigned    quiet_cycles;
    int unsigned    items_sent;
    int unsigned    settings_used;

    gaussian_blur_3x3_rgb u_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in       (in_ch),
        .o_out      (out_ch),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // Random output back-pressure bursts, started only while idling_on is set.
    always @(negedge i_clk) begin
        if (stall_left != 0) begin
            stall_left--;
        end else if (idling_on && $urandom_range(0, 5) == 0) begin
            stall_left = $urandom_range(1, 3);
        end
        out_ch.ready = (stall_left == 0);
    end

    always @(posedge i_clk) begin
        t_blur_pixel seen;
        if (i_rst_n) begin
            if (i_cfg_we) board.write_register(i_cfg_idx, i_cfg_data);
            if (in_ch.valid && in_ch.ready)
                board.note_input(in_ch.func, {in_ch.in_red, in_ch.in_green, in_ch.in_blue});
            if (out_ch.valid && out_ch.ready) begin
                seen.out_blue     = out_ch.out_blue;
                seen.out_green    = out_ch.out_green;
                seen.out_red      = out_ch.out_red;
                seen.end_of_image = out_ch.end_of_image;
                board.check_result(seen);
            end
            if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
                quiet_cycles = 0;
            end else begin
                quiet_cycles++;
            end
        end
    end

    initial begin
        while (quiet_cycles < STALL_LIMIT) @(posedge i_clk);
        $display("gaussian_blur_3x3_rgb_tb: errors");
        $finish;
    end

    // Called at a falling edge; returns at the falling edge after the item is taken.
    task automatic send_item(input bit flush, input logic [PIX_W-1:0] pix);
        if (idling_on && $urandom_range(0, 5) == 0) begin
            in_ch.valid = 1'b0;
            repeat ($urandom_range(1, 3)) @(negedge i_clk);
        end
        in_ch.valid = 1'b1;
        in_ch.func  = flush;
        {in_ch.in_red, in_ch.in_green, in_ch.in_blue} = pix;
        @(posedge i_clk);
        while (!in_ch.ready) @(posedge i_clk);
        @(negedge i_clk);
        items_sent++;
    endtask

    // Waits until every pending pixel is out and the block has gone quiet.
    task automatic settle();
        in_ch.valid = 1'b0;
        while (board.expected_pixels.size() != 0) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] value);
        i_cfg_we   = 1'b1;
        i_cfg_idx  = idx;
        i_cfg_data = value;
        @(negedge i_clk);
        i_cfg_we = 1'b0;
    endtask

    // One image in raster order with stray flushes during fill and pixels during drain.
    // A nonzero cut stops after that many pixels and leaves the image unfinished.
    task automatic send_image(input int unsigned w, input int unsigned h, input int unsigned cut);
        int unsigned pixels;
        int unsigned ticks;
        pixels = w * h;
        ticks  = (h == 1) ? w : w + 1;
        if (cut != 0) begin
            pixels = cut;
            ticks  = 0;
        end
        for (int unsigned i = 0; i < pixels; i++) begin
            if ($urandom_range(0, 9) == 0) send_item(FUNC_FLUSH, PIX_W'($urandom));
            send_item(FUNC_PIXEL, PIX_W'($urandom));
        end
        for (int unsigned i = 0; i < ticks; i++) begin
            send_item(($urandom_range(0, 3) == 0) ? FUNC_PIXEL : FUNC_FLUSH,
                      PIX_W'($urandom));
        end
    endtask

    task automatic set_frame(input logic [CFG_DATA_W-1:0] wv, input logic [CFG_DATA_W-1:0] hv);
        settle();
        if ($urandom_range(0, 1)) begin
            cfg_write(CFG_IMAGE_WIDTH, wv);
            cfg_write(CFG_IMAGE_HEIGHT, hv);
        end else begin
            cfg_write(CFG_IMAGE_HEIGHT, hv);
            cfg_write(CFG_IMAGE_WIDTH, wv);
        end
        settings_used++;
    endtask

    initial begin
        logic [PIX_W-1:0]      grid [9] = '{24'hFFFFFF, 24'hFFFFFF, 24'h000000,
                                            24'hFFFFFF, 24'hFFFFFF, 24'h80FF01,
                                            24'hFFFFFF, 24'h3C5AA5, 24'hFFFFFF};
        logic [CFG_DATA_W-1:0] wv;
        logic [CFG_DATA_W-1:0] hv;
        int unsigned           w;
        int unsigned           h;

        in_ch.valid    = 1'b0;
        in_ch.func     = FUNC_PIXEL;
        in_ch.in_blue  = '0;
        in_ch.in_green = '0;
        in_ch.in_red   = '0;
        out_ch.ready   = 1'b0;
        i_cfg_we       = 1'b0;
        i_cfg_idx      = CFG_IMAGE_WIDTH;
        i_cfg_data     = '0;
        idling_on      = 1'b1;
        stall_left     = 0;
        quiet_cycles   = 0;
        items_sent     = 0;
        settings_used  = 0;
        board          = new();

        repeat (10) @(negedge i_clk);
        i_rst_n = 1'b1;

        // Zero width and height both act as one: single-pixel images, with a
        // flush before the image and a pixel standing in for the drain tick.
        set_frame(16'd0, 16'd0);
        send_item(FUNC_FLUSH, 24'h123456);
        send_item(FUNC_PIXEL, 24'hFFFFFF);
        send_item(FUNC_FLUSH, 24'h000000);
        send_item(FUNC_PIXEL, 24'h000000);
        send_item(FUNC_PIXEL, 24'h5AA53C);

        // One-row image: edge weight 6, inner weight 8, double push on first tick.
        set_frame(16'd3, 16'd1);
        send_item(FUNC_PIXEL, 24'hFFFFFF);
        send_item(FUNC_PIXEL, 24'hFFFFFF);
        send_item(FUNC_PIXEL, 24'h01807F);
        send_item(FUNC_FLUSH, 24'hFFFFFF);
        send_item(FUNC_PIXEL, 24'hA5A5A5);
        send_item(FUNC_FLUSH, 24'h000000);

        // 3x3 image: corner weight 9, edge 12 and a full kernel at the center.
        set_frame(16'd3, 16'd3);
        foreach (grid[i]) send_item(FUNC_PIXEL, grid[i]);
        send_item(FUNC_FLUSH, 24'h000000);
        send_item(FUNC_PIXEL, 24'hFFFFFF);
        send_item(FUNC_FLUSH, 24'hFFFFFF);
        send_item(FUNC_FLUSH, 24'h000000);

        while (items_sent < ITEM_TARGET) begin
            if (settings_used == 5) begin
                // Width register beyond the line store, tallest possible image.
                wv = 16'd4095;
                hv = 16'd65535;
            end else begin
                case ($urandom_range(0, 9))
                    0: begin wv = 16'd0; hv = CFG_DATA_W'($urandom_range(1, 5)); end
                    1: begin wv = CFG_DATA_W'($urandom_range(1, 9)); hv = 16'd0; end
                    2: begin wv = 16'd1; hv = CFG_DATA_W'($urandom_range(1, 12)); end
                    3: begin wv = CFG_DATA_W'($urandom_range(2, 20)); hv = 16'd1; end
                    4: begin wv = CFG_DATA_W'($urandom_range(1, 6)); hv = 16'd65535; end
                    5: begin wv = 16'd2; hv = 16'd2; end
                    default: begin
                        wv = CFG_DATA_W'($urandom_range(2, 12));
                        hv = CFG_DATA_W'($urandom_range(2, 8));
                    end
                endcase
            end
            idling_on = (items_sent + CALM_TAIL < ITEM_TARGET) && ($urandom_range(0, 3) != 0);
            set_frame(wv, hv);
            w = board.frame_width();
            h = board.frame_height();
            if (w * h > 400) begin
                send_image(w, h, $urandom_range(1, 40));
            end else if ($urandom_range(0, 7) == 0) begin
                send_image(w, h, $urandom_range(1, w * h));
            end else begin
                repeat ($urandom_range(1, 3)) send_image(w, h, 0);
            end
        end

        in_ch.valid = 1'b0;
        while (board.expected_pixels.size() != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);

        $display("Sent %0d items over %0d frame settings (1x1 to 2048 wide, heights to 65535).",
                 items_sent, settings_used);
        $display("Checked %0d blurred pixels, %0d complete images, %0d mismatches.",
                 board.checked, board.images_done, board.mismatches);
        if (board.mismatches == 0) begin
            $display("gaussian_blur_3x3_rgb_tb: clean");
        end else begin
            $display("gaussian_blur_3x3_rgb_tb: errors");
        end
        $finish;
    end

endmodule
